// ===== rtl/attest_quote_stream_parser_unit_assert.svh =====
// Assertion macros used by the parser RTL.
`ifndef ATTEST_QUOTE_STREAM_PARSER_UNIT_ASSERT_SVH
`define ATTEST_QUOTE_STREAM_PARSER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AQSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AQSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser assertion failed");

`endif

// ===== rtl/aqsp_pkg.sv =====
package aqsp_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_MAGIC = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TAG   = 1'd1;

    localparam logic [31:0] MAGIC_RESET = 32'hFF54_4347;
    localparam logic [15:0] TAG_RESET   = 16'h8018;

    localparam logic [4:0] PH_MAGIC    = 5'd0;
    localparam logic [4:0] PH_TYPE     = 5'd1;
    localparam logic [4:0] PH_SLEN     = 5'd2;
    localparam logic [4:0] PH_SBYTES   = 5'd3;
    localparam logic [4:0] PH_XLEN     = 5'd4;
    localparam logic [4:0] PH_XBYTES   = 5'd5;
    localparam logic [4:0] PH_CLOCK    = 5'd6;
    localparam logic [4:0] PH_RESETS   = 5'd7;
    localparam logic [4:0] PH_RESTARTS = 5'd8;
    localparam logic [4:0] PH_SAFE     = 5'd9;
    localparam logic [4:0] PH_FW       = 5'd10;
    localparam logic [4:0] PH_SELCNT   = 5'd11;
    localparam logic [4:0] PH_HASH     = 5'd12;
    localparam logic [4:0] PH_SELSIZE  = 5'd13;
    localparam logic [4:0] PH_SELBYTES = 5'd14;
    localparam logic [4:0] PH_DIGSIZE  = 5'd15;
    localparam logic [4:0] PH_DIGBYTES = 5'd16;
    localparam logic [4:0] PH_DONE     = 5'd17;

    localparam logic [3:0] FC_SIGNER   = 4'd0;
    localparam logic [3:0] FC_EXTRA    = 4'd1;
    localparam logic [3:0] FC_CLOCK    = 4'd2;
    localparam logic [3:0] FC_RESETS   = 4'd3;
    localparam logic [3:0] FC_RESTARTS = 4'd4;
    localparam logic [3:0] FC_SAFE     = 4'd5;
    localparam logic [3:0] FC_FW       = 4'd6;
    localparam logic [3:0] FC_SELCNT   = 4'd7;
    localparam logic [3:0] FC_HASH     = 4'd8;
    localparam logic [3:0] FC_SELSIZE  = 4'd9;
    localparam logic [3:0] FC_SELBYTE  = 4'd10;
    localparam logic [3:0] FC_DIGSIZE  = 4'd11;
    localparam logic [3:0] FC_DIGBYTE  = 4'd12;
    localparam logic [3:0] FC_STATUS   = 4'd13;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_COMPLETE    = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
    localparam logic [2:0] ST_NOT_QUOTE   = 3'd3;
    localparam logic [2:0] ST_ZERO_DIGEST = 3'd4;
    localparam logic [2:0] ST_TOO_SHORT   = 3'd5;

    localparam logic [1:0] FLAG_ERROR    = 2'b01;
    localparam logic [1:0] FLAG_COMPLETE = 2'b10;

    typedef struct packed {
        logic [4:0]  phase;
        logic [3:0]  byte_in_field;
        logic [63:0] accumulator;
        logic [15:0] bytes_remaining;
        logic [31:0] selections_remaining;
        logic [31:0] selection_index;
        logic [1:0]  flags;
    } aqsp_state_t;

    localparam aqsp_state_t STATE_RESET = '{
        phase: PH_MAGIC,
        byte_in_field: 4'd0,
        accumulator: 64'd0,
        bytes_remaining: 16'd0,
        selections_remaining: 32'd0,
        selection_index: 32'd0,
        flags: 2'b00
    };

    typedef struct packed {
        logic [3:0]  field_code;
        logic [31:0] item_index;
        logic [63:0] field_value;
        logic [2:0]  status;
        logic        last;
    } aqsp_result_t;

    // Number of bytes in a fixed-width field; zero marks a byte-string phase (or PH_DONE).
    function automatic logic [3:0] field_len(input logic [4:0] phase);
        logic [3:0] len;
        case (phase)
            PH_MAGIC:    len = 4'd4;
            PH_TYPE:     len = 4'd2;
            PH_SLEN:     len = 4'd2;
            PH_XLEN:     len = 4'd2;
            PH_CLOCK:    len = 4'd8;
            PH_RESETS:   len = 4'd4;
            PH_RESTARTS: len = 4'd4;
            PH_SAFE:     len = 4'd1;
            PH_FW:       len = 4'd8;
            PH_SELCNT:   len = 4'd4;
            PH_HASH:     len = 4'd2;
            PH_SELSIZE:  len = 4'd1;
            PH_DIGSIZE:  len = 4'd2;
            default:     len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/aqsp_in_if.sv =====
interface aqsp_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink (input valid, input op, input data_byte, output ready);
endinterface

// ===== rtl/aqsp_out_if.sv =====
interface aqsp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  field_code;
    logic [31:0] item_index;
    logic [63:0] field_value;
    logic [2:0]  status;
    logic        last;

    modport source (output valid, output field_code, output item_index, output field_value,
                    output status, output last, input ready);
    modport sink (input valid, input field_code, input item_index, input field_value,
                  input status, input last, output ready);
endinterface

// ===== rtl/aqsp_step.sv =====
module aqsp_step (
    input  aqsp_pkg::aqsp_state_t  state,
    input  logic                   op,
    input  logic [7:0]             data_byte,
    input  logic [31:0]            magic_value,
    input  logic [15:0]            quote_type_tag,
    output aqsp_pkg::aqsp_state_t  state_next,
    output logic                   result_valid,
    output aqsp_pkg::aqsp_result_t result
);
    import aqsp_pkg::*;

    logic [63:0] acc_shift;
    logic [3:0]  bif_inc;
    logic [3:0]  len;
    logic [15:0] str_idx;
    logic [15:0] br_dec;
    logic [31:0] sel_rem_dec;
    logic [31:0] sel_idx_inc;
    logic [3:0]  str_code;

    assign acc_shift   = {state.accumulator[55:0], data_byte};
    assign bif_inc     = state.byte_in_field + 4'd1;
    assign len         = field_len(state.phase);
    assign str_idx     = state.accumulator[15:0] - state.bytes_remaining;
    assign br_dec      = state.bytes_remaining - 16'd1;
    assign sel_rem_dec = state.selections_remaining - 32'd1;
    assign sel_idx_inc = state.selection_index + 32'd1;

    always_comb
    begin
        case (state.phase)
            PH_SBYTES:   str_code = FC_SIGNER;
            PH_XBYTES:   str_code = FC_EXTRA;
            PH_SELBYTES: str_code = FC_SELBYTE;
            default:     str_code = FC_DIGBYTE;
        endcase
    end

    always_comb
    begin
        state_next   = state;
        result_valid = 1'b0;
        result       = '{field_code: FC_STATUS, item_index: 32'd0, field_value: 64'd0,
                         status: ST_OK, last: 1'b0};

        if (op)
        begin
            result_valid  = (state.flags == 2'b00);
            result.status = ST_TOO_SHORT;
            result.last   = 1'b1;
            state_next    = STATE_RESET;
        end
        else if (state.flags != 2'b00 || state.phase >= PH_DONE)
        begin
            state_next = state;
        end
        else if (len == 4'd0)
        begin
            result_valid               = 1'b1;
            result.field_code          = str_code;
            result.item_index          = {16'd0, str_idx};
            result.field_value         = {56'd0, data_byte};
            state_next.bytes_remaining = br_dec;
            if (br_dec == 16'd0)
            begin
                state_next.accumulator = 64'd0;
                case (state.phase)
                    PH_SBYTES:   state_next.phase = PH_XLEN;
                    PH_XBYTES:   state_next.phase = PH_CLOCK;
                    PH_SELBYTES:
                    begin
                        state_next.selection_index      = sel_idx_inc;
                        state_next.selections_remaining = sel_rem_dec;
                        state_next.phase = (sel_rem_dec == 32'd0) ? PH_DIGSIZE : PH_HASH;
                    end
                    default:
                    begin
                        state_next.phase = PH_DONE;
                        state_next.flags = state.flags | FLAG_COMPLETE;
                        result.status    = ST_COMPLETE;
                        result.last      = 1'b1;
                    end
                endcase
            end
        end
        else if (bif_inc < len)
        begin
            state_next.accumulator   = acc_shift;
            state_next.byte_in_field = bif_inc;
        end
        else
        begin
            state_next.accumulator   = 64'd0;
            state_next.byte_in_field = 4'd0;
            case (state.phase)
                PH_MAGIC:
                begin
                    if (acc_shift[31:0] != magic_value)
                    begin
                        state_next.flags   = state.flags | FLAG_ERROR;
                        result_valid       = 1'b1;
                        result.field_value = {32'd0, acc_shift[31:0]};
                        result.status      = ST_BAD_MAGIC;
                        result.last        = 1'b1;
                    end
                    else
                    begin
                        state_next.phase = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    if (acc_shift[15:0] != quote_type_tag)
                    begin
                        state_next.flags   = state.flags | FLAG_ERROR;
                        result_valid       = 1'b1;
                        result.field_value = {48'd0, acc_shift[15:0]};
                        result.status      = ST_NOT_QUOTE;
                        result.last        = 1'b1;
                    end
                    else
                    begin
                        state_next.phase = PH_SLEN;
                    end
                end
                PH_SLEN, PH_XLEN:
                begin
                    state_next.bytes_remaining = acc_shift[15:0];
                    state_next.accumulator     = {48'd0, acc_shift[15:0]};
                    if (acc_shift[15:0] == 16'd0)
                    begin
                        state_next.phase = (state.phase == PH_SLEN) ? PH_XLEN : PH_CLOCK;
                    end
                    else
                    begin
                        state_next.phase = (state.phase == PH_SLEN) ? PH_SBYTES : PH_XBYTES;
                    end
                end
                PH_CLOCK:
                begin
                    state_next.phase   = PH_RESETS;
                    result_valid       = 1'b1;
                    result.field_code  = FC_CLOCK;
                    result.field_value = acc_shift;
                end
                PH_RESETS:
                begin
                    state_next.phase   = PH_RESTARTS;
                    result_valid       = 1'b1;
                    result.field_code  = FC_RESETS;
                    result.field_value = {32'd0, acc_shift[31:0]};
                end
                PH_RESTARTS:
                begin
                    state_next.phase   = PH_SAFE;
                    result_valid       = 1'b1;
                    result.field_code  = FC_RESTARTS;
                    result.field_value = {32'd0, acc_shift[31:0]};
                end
                PH_SAFE:
                begin
                    state_next.phase   = PH_FW;
                    result_valid       = 1'b1;
                    result.field_code  = FC_SAFE;
                    result.field_value = {56'd0, acc_shift[7:0]};
                end
                PH_FW:
                begin
                    state_next.phase   = PH_SELCNT;
                    result_valid       = 1'b1;
                    result.field_code  = FC_FW;
                    result.field_value = acc_shift;
                end
                PH_SELCNT:
                begin
                    state_next.selections_remaining = acc_shift[31:0];
                    state_next.selection_index      = 32'd0;
                    state_next.phase = (acc_shift[31:0] == 32'd0) ? PH_DIGSIZE : PH_HASH;
                    result_valid       = 1'b1;
                    result.field_code  = FC_SELCNT;
                    result.field_value = {32'd0, acc_shift[31:0]};
                end
                PH_HASH:
                begin
                    state_next.phase   = PH_SELSIZE;
                    result_valid       = 1'b1;
                    result.field_code  = FC_HASH;
                    result.item_index  = state.selection_index;
                    result.field_value = {48'd0, acc_shift[15:0]};
                end
                PH_SELSIZE:
                begin
                    state_next.bytes_remaining = {8'd0, acc_shift[7:0]};
                    if (acc_shift[7:0] == 8'd0)
                    begin
                        state_next.selection_index      = sel_idx_inc;
                        state_next.selections_remaining = sel_rem_dec;
                        state_next.phase = (sel_rem_dec == 32'd0) ? PH_DIGSIZE : PH_HASH;
                    end
                    else
                    begin
                        state_next.accumulator = {56'd0, acc_shift[7:0]};
                        state_next.phase       = PH_SELBYTES;
                    end
                    result_valid       = 1'b1;
                    result.field_code  = FC_SELSIZE;
                    result.item_index  = state.selection_index;
                    result.field_value = {56'd0, acc_shift[7:0]};
                end
                PH_DIGSIZE:
                begin
                    result_valid      = 1'b1;
                    result.field_code = FC_DIGSIZE;
                    if (acc_shift[15:0] == 16'd0)
                    begin
                        state_next.flags = state.flags | FLAG_ERROR;
                        result.status    = ST_ZERO_DIGEST;
                        result.last      = 1'b1;
                    end
                    else
                    begin
                        state_next.bytes_remaining = acc_shift[15:0];
                        state_next.accumulator     = {48'd0, acc_shift[15:0]};
                        state_next.phase           = PH_DIGBYTES;
                        result.field_value         = {48'd0, acc_shift[15:0]};
                    end
                end
                default:
                begin
                    state_next.phase = PH_DONE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/attest_quote_stream_parser_unit.sv =====
// Results go into the head register, or the skid register while the head is held.
// Throughput: one byte per cycle while the skid is empty; state updates on accept.
// A two-entry output buffer keeps bytes flowing while one result waits downstream.
// Reset is asynchronous and active low; it returns the parser to the start of a quote,
// empties the output buffer and loads the default magic word and structure tag.
module attest_quote_stream_parser_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    aqsp_in_if.sink                          byte_stream,
    aqsp_out_if.source                       result_stream,
    input  logic                             cfg_we,
    input  logic [aqsp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [aqsp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import aqsp_pkg::*;

    `include "attest_quote_stream_parser_unit_assert.svh"

    aqsp_state_t  state_reg;
    aqsp_state_t  state_next;
    aqsp_result_t step_result;
    logic         step_valid;

    logic [31:0]  magic_reg;
    logic [15:0]  tag_reg;

    aqsp_result_t head_reg;
    aqsp_result_t skid_reg;
    logic         head_valid_reg;
    logic         head_valid_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    logic         head_load_new;
    logic         head_load_skid;
    logic         skid_load;

    logic         accept;
    logic         push;
    logic         pop;

    aqsp_step u_step (
        .state          (state_reg),
        .op             (byte_stream.op),
        .data_byte      (byte_stream.data_byte),
        .magic_value    (magic_reg),
        .quote_type_tag (tag_reg),
        .state_next     (state_next),
        .result_valid   (step_valid),
        .result         (step_result)
    );

    assign byte_stream.ready = !skid_valid_reg;
    assign accept            = byte_stream.valid && byte_stream.ready;
    assign push              = accept && step_valid;
    assign pop               = head_valid_reg && result_stream.ready;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_load_new   = 1'b0;
        head_load_skid  = 1'b0;
        skid_load       = 1'b0;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                head_load_skid  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (head_valid_reg)
        begin
            if (push && pop)
            begin
                head_load_new = 1'b1;
            end
            else if (push)
            begin
                skid_load       = 1'b1;
                skid_valid_next = 1'b1;
            end
            else if (pop)
            begin
                head_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            head_load_new   = 1'b1;
            head_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= STATE_RESET;
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
            magic_reg      <= MAGIC_RESET;
            tag_reg        <= TAG_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAGIC: magic_reg <= cfg_data[31:0];
                    REG_TAG:   tag_reg   <= cfg_data[15:0];
                    default:   magic_reg <= magic_reg;
                endcase
            end
            if (accept)
            begin
                state_reg <= state_next;
            end
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_load_new)
        begin
            head_reg <= step_result;
        end
        else if (head_load_skid)
        begin
            head_reg <= skid_reg;
        end
        if (skid_load)
        begin
            skid_reg <= step_result;
        end
    end

    assign result_stream.valid       = head_valid_reg;
    assign result_stream.field_code  = head_reg.field_code;
    assign result_stream.item_index  = head_reg.item_index;
    assign result_stream.field_value = head_reg.field_value;
    assign result_stream.status      = head_reg.status;
    assign result_stream.last        = head_reg.last;

    `AQSP_ASSERT_IMPL(a_skid_needs_head, clk, rst_n, skid_valid_reg, head_valid_reg)
    `AQSP_ASSERT_IMPL(a_silent_after_outcome, clk, rst_n,
        accept && !byte_stream.op && state_reg.flags != 2'b00, !step_valid)
    `AQSP_ASSERT_IMPL(a_done_is_complete, clk, rst_n,
        state_reg.phase == PH_DONE, state_reg.flags == FLAG_COMPLETE)
    `AQSP_ASSERT_NEXT(a_end_clears, clk, rst_n, accept && byte_stream.op,
        state_reg.phase == PH_MAGIC && state_reg.flags == 2'b00)
    `AQSP_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n,
        push && head_valid_reg && !pop, skid_valid_reg)

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import aqsp_pkg::*;

    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int ITEMS_PER_SETTING = 170;
    localparam int REPORT_LIMIT      = 10;

    typedef struct packed {
        logic         op;
        logic [7:0]   data;
        logic         typed;
        logic         want;
        aqsp_result_t res;
    } step_row_t;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } stream_item_t;

    localparam aqsp_result_t NO_RESULT = '0;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    aqsp_in_if  bs();
    aqsp_out_if rs();

    attest_quote_stream_parser_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_stream   (bs),
        .result_stream (rs),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    aqsp_result_t expected_fields[$];
    stream_item_t quote_bytes[$];
    step_row_t    directed_rows[$];
    int           error_count = 0;
    int           idle_cycles = 0;
    bit           steady_sender = 1'b0;

    // Parser state as the block should hold it.
    logic [31:0] want_magic = MAGIC_RESET;
    logic [15:0] want_tag   = TAG_RESET;
    logic [4:0]  q_phase    = PH_MAGIC;
    logic [3:0]  q_count    = '0;
    logic [63:0] q_acc      = '0;
    logic [15:0] q_left     = '0;
    logic [31:0] q_sel_left = '0;
    logic [31:0] q_sel_idx  = '0;
    logic [1:0]  q_flags    = '0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic aqsp_result_t mk_result(input logic [3:0] code, input logic [31:0] idx,
                                               input logic [63:0] val, input logic [2:0] st,
                                               input logic last);
        aqsp_result_t r;
        r.field_code  = code;
        r.item_index  = idx;
        r.field_value = val;
        r.status      = st;
        r.last        = last;
        return r;
    endfunction

    function automatic step_row_t mk_row(input logic op, input logic [7:0] data,
                                         input logic typed, input logic want,
                                         input aqsp_result_t res);
        step_row_t row;
        row.op    = op;
        row.data  = data;
        row.typed = typed;
        row.want  = want;
        row.res   = res;
        return row;
    endfunction

    function automatic logic [3:0] fixed_bytes(input logic [4:0] ph);
        logic [3:0] n;
        case (ph)
            PH_MAGIC:    n = 4'd4;
            PH_TYPE:     n = 4'd2;
            PH_SLEN:     n = 4'd2;
            PH_XLEN:     n = 4'd2;
            PH_CLOCK:    n = 4'd8;
            PH_RESETS:   n = 4'd4;
            PH_RESTARTS: n = 4'd4;
            PH_SAFE:     n = 4'd1;
            PH_FW:       n = 4'd8;
            PH_SELCNT:   n = 4'd4;
            PH_HASH:     n = 4'd2;
            PH_SELSIZE:  n = 4'd1;
            PH_DIGSIZE:  n = 4'd2;
            default:     n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 5);
        return $urandom_range(20, 40);
    endfunction

    task automatic advance_selection();
        q_acc      = '0;
        q_sel_idx  = q_sel_idx + 1;
        q_sel_left = q_sel_left - 1;
        q_phase    = (q_sel_left == 0) ? PH_DIGSIZE : PH_HASH;
    endtask

    task automatic parse_quote_byte(input logic op, input logic [7:0] b,
                                    output bit emitted, output aqsp_result_t r);
        logic [3:0]  n;
        logic [63:0] v;
        logic [15:0] pos;
        logic [3:0]  code;
        emitted = 1'b0;
        r       = NO_RESULT;
        if (op)
        begin
            if (q_flags == 2'b00)
            begin
                emitted = 1'b1;
                r = mk_result(FC_STATUS, 0, 0, ST_TOO_SHORT, 1'b1);
            end
            q_phase    = PH_MAGIC;
            q_count    = '0;
            q_acc      = '0;
            q_left     = '0;
            q_sel_left = '0;
            q_sel_idx  = '0;
            q_flags    = '0;
        end
        else if (q_flags == 2'b00 && q_phase < PH_DONE)
        begin
            n = fixed_bytes(q_phase);
            if (n == 0)
            begin
                pos  = q_acc[15:0] - q_left;
                code = (q_phase == PH_SBYTES)   ? FC_SIGNER :
                       (q_phase == PH_XBYTES)   ? FC_EXTRA :
                       (q_phase == PH_SELBYTES) ? FC_SELBYTE : FC_DIGBYTE;
                q_left  = q_left - 1;
                emitted = 1'b1;
                r = mk_result(code, {16'd0, pos}, {56'd0, b}, ST_OK, 1'b0);
                if (q_left == 0)
                begin
                    q_acc = '0;
                    case (q_phase)
                        PH_SBYTES:   q_phase = PH_XLEN;
                        PH_XBYTES:   q_phase = PH_CLOCK;
                        PH_SELBYTES: advance_selection();
                        default:
                        begin
                            q_phase  = PH_DONE;
                            q_flags |= FLAG_COMPLETE;
                            r.status = ST_COMPLETE;
                            r.last   = 1'b1;
                        end
                    endcase
                end
            end
            else
            begin
                q_acc   = {q_acc[55:0], b};
                q_count = q_count + 1;
                if (q_count >= n)
                begin
                    q_count = '0;
                    v       = q_acc;
                    q_acc   = '0;
                    case (q_phase)
                        PH_MAGIC:
                        begin
                            if (v[31:0] != want_magic)
                            begin
                                q_flags |= FLAG_ERROR;
                                emitted  = 1'b1;
                                r = mk_result(FC_STATUS, 0, {32'd0, v[31:0]}, ST_BAD_MAGIC, 1'b1);
                            end
                            else
                            begin
                                q_phase = PH_TYPE;
                            end
                        end
                        PH_TYPE:
                        begin
                            if (v[15:0] != want_tag)
                            begin
                                q_flags |= FLAG_ERROR;
                                emitted  = 1'b1;
                                r = mk_result(FC_STATUS, 0, {48'd0, v[15:0]}, ST_NOT_QUOTE, 1'b1);
                            end
                            else
                            begin
                                q_phase = PH_SLEN;
                            end
                        end
                        PH_SLEN, PH_XLEN:
                        begin
                            q_left = v[15:0];
                            if (q_left == 0)
                            begin
                                q_phase = (q_phase == PH_SLEN) ? PH_XLEN : PH_CLOCK;
                            end
                            else
                            begin
                                q_acc   = {48'd0, q_left};
                                q_phase = (q_phase == PH_SLEN) ? PH_SBYTES : PH_XBYTES;
                            end
                        end
                        PH_CLOCK:
                        begin
                            q_phase = PH_RESETS;
                            emitted = 1'b1;
                            r = mk_result(FC_CLOCK, 0, v, ST_OK, 1'b0);
                        end
                        PH_RESETS:
                        begin
                            q_phase = PH_RESTARTS;
                            emitted = 1'b1;
                            r = mk_result(FC_RESETS, 0, {32'd0, v[31:0]}, ST_OK, 1'b0);
                        end
                        PH_RESTARTS:
                        begin
                            q_phase = PH_SAFE;
                            emitted = 1'b1;
                            r = mk_result(FC_RESTARTS, 0, {32'd0, v[31:0]}, ST_OK, 1'b0);
                        end
                        PH_SAFE:
                        begin
                            q_phase = PH_FW;
                            emitted = 1'b1;
                            r = mk_result(FC_SAFE, 0, {56'd0, v[7:0]}, ST_OK, 1'b0);
                        end
                        PH_FW:
                        begin
                            q_phase = PH_SELCNT;
                            emitted = 1'b1;
                            r = mk_result(FC_FW, 0, v, ST_OK, 1'b0);
                        end
                        PH_SELCNT:
                        begin
                            q_sel_left = v[31:0];
                            q_sel_idx  = '0;
                            q_phase    = (q_sel_left == 0) ? PH_DIGSIZE : PH_HASH;
                            emitted    = 1'b1;
                            r = mk_result(FC_SELCNT, 0, {32'd0, v[31:0]}, ST_OK, 1'b0);
                        end
                        PH_HASH:
                        begin
                            q_phase = PH_SELSIZE;
                            emitted = 1'b1;
                            r = mk_result(FC_HASH, q_sel_idx, {48'd0, v[15:0]}, ST_OK, 1'b0);
                        end
                        PH_SELSIZE:
                        begin
                            emitted = 1'b1;
                            r = mk_result(FC_SELSIZE, q_sel_idx, {56'd0, v[7:0]}, ST_OK, 1'b0);
                            q_left = {8'd0, v[7:0]};
                            if (q_left == 0)
                            begin
                                advance_selection();
                            end
                            else
                            begin
                                q_acc   = {48'd0, q_left};
                                q_phase = PH_SELBYTES;
                            end
                        end
                        PH_DIGSIZE:
                        begin
                            emitted = 1'b1;
                            if (v[15:0] == 0)
                            begin
                                q_flags |= FLAG_ERROR;
                                r = mk_result(FC_DIGSIZE, 0, 0, ST_ZERO_DIGEST, 1'b1);
                            end
                            else
                            begin
                                q_left  = v[15:0];
                                q_acc   = {48'd0, q_left};
                                q_phase = PH_DIGBYTES;
                                r = mk_result(FC_DIGSIZE, 0, {48'd0, v[15:0]}, ST_OK, 1'b0);
                            end
                        end
                        default:
                        begin
                            q_phase = PH_DONE;
                        end
                    endcase
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input aqsp_result_t want,
                                   input aqsp_result_t got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
        begin
            $write("%s: expected code %0d index %0d value %h status %0d last %0d, ",
                   what, want.field_code, want.item_index, want.field_value, want.status,
                   want.last);
            $display("got code %0d index %0d value %h status %0d last %0d",
                     got.field_code, got.item_index, got.field_value, got.status, got.last);
        end
    endtask

    task automatic send_item(input logic op, input logic [7:0] b, input logic typed,
                             input logic want, input aqsp_result_t res);
        int           gap;
        bit           emitted;
        aqsp_result_t r;
        gap = steady_sender ? 0 : pick_gap();
        if (gap > 0)
        begin
            bs.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bs.valid     <= 1'b1;
        bs.op        <= op;
        bs.data_byte <= b;
        @(posedge clk);
        while (bs.ready !== 1'b1) @(posedge clk);
        parse_quote_byte(op, b, emitted, r);
        if (typed)
        begin
            emitted = want;
            r       = res;
        end
        if (emitted)
            expected_fields.push_back(r);
    endtask

    task automatic wait_idle();
        bs.valid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_MAGIC)
            want_magic = val;
        else
            want_tag = val[15:0];
    endtask

    task automatic push_be(input logic [63:0] v, input int n);
        int i;
        for (i = n - 1; i >= 0; i--)
            quote_bytes.push_back({1'b0, v[8*i +: 8]});
    endtask

    task automatic build_quote();
        int          kind;
        int          n;
        int          pos;
        int          nsel;
        int          ssz;
        int          dsize;
        logic [31:0] magic_word;
        logic [15:0] tag_word;
        quote_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 95)
        begin
            n = $urandom_range(1, 20);
            repeat (n) quote_bytes.push_back({($urandom_range(0, 4) == 0), 8'($urandom)});
        end
        else
        begin
            magic_word = (kind >= 78 && kind < 84) ? $urandom : want_magic;
            tag_word   = (kind >= 84 && kind < 90) ? 16'($urandom) : want_tag;
            push_be(64'(magic_word), 4);
            push_be(64'(tag_word), 2);
            n = pick_len();
            push_be(64'(n), 2);
            repeat (n) push_be(64'($urandom), 1);
            n = pick_len();
            push_be(64'(n), 2);
            repeat (n) push_be(64'($urandom), 1);
            push_be({$urandom, $urandom}, 8);
            push_be(64'($urandom), 4);
            push_be(64'($urandom), 4);
            push_be(64'($urandom), 1);
            push_be({$urandom, $urandom}, 8);
            nsel = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
            push_be(64'(nsel), 4);
            repeat (nsel)
            begin
                push_be(64'($urandom), 2);
                ssz = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
                push_be(64'(ssz), 1);
                repeat (ssz) push_be(64'($urandom), 1);
            end
            if (kind >= 90)
                dsize = 0;
            else
                dsize = ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(1, 8);
            push_be(64'(dsize), 2);
            // Trailing bytes after the digest, or after a zero size, are to be ignored.
            repeat (dsize + $urandom_range(0, 3)) push_be(64'($urandom), 1);
            if (kind >= 60 && kind < 70)
            begin
                pos = $urandom_range(0, quote_bytes.size() - 1);
                while (quote_bytes.size() > pos) void'(quote_bytes.pop_back());
            end
            else if (kind >= 70 && kind < 78)
            begin
                pos = $urandom_range(0, quote_bytes.size() - 1);
                quote_bytes[pos].data ^= 8'($urandom_range(1, 255));
            end
        end
        quote_bytes.push_back({1'b1, 8'($urandom)});
    endtask

    always @(posedge clk)
    begin : check_results
        aqsp_result_t got;
        aqsp_result_t want;
        if (rst_n === 1'b1 && rs.valid === 1'b1 && rs.ready === 1'b1)
        begin
            got = mk_result(rs.field_code, rs.item_index, rs.field_value, rs.status, rs.last);
            if (expected_fields.size() == 0)
            begin
                report_mismatch("result with nothing expected", NO_RESULT, got);
            end
            else
            begin
                want = expected_fields.pop_front();
                if (got !== want)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((bs.valid === 1'b1 && bs.ready === 1'b1) || (rs.valid === 1'b1 && rs.ready === 1'b1))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin : result_sink
        int run;
        int stall;
        rs.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            run = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
            rs.ready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                rs.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int          sent;
        int          setting;
        logic [31:0] m;
        logic [15:0] t;
        bs.valid     <= 1'b0;
        bs.op        <= 1'b0;
        bs.data_byte <= 8'h00;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_MAGIC;
        cfg_data     <= '0;
        rst_n        <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // End of stream straight after reset, an all-zero magic word, ignored bytes after an
        // error, a wrong structure tag and a quote cut short just after the signer string.
        directed_rows.push_back(mk_row(1'b1, 8'h00, 1'b1, 1'b1,
                                       mk_result(FC_STATUS, 0, 0, ST_TOO_SHORT, 1'b1)));
        repeat (3) directed_rows.push_back(mk_row(1'b0, 8'h00, 1'b1, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b0, 8'h00, 1'b1, 1'b1,
                                       mk_result(FC_STATUS, 0, 0, ST_BAD_MAGIC, 1'b1)));
        directed_rows.push_back(mk_row(1'b0, 8'hFF, 1'b1, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b1, 8'hFF, 1'b1, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b0, 8'hFF, 1'b1, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b0, 8'h54, 1'b1, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b0, 8'h43, 1'b1, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b0, 8'h47, 1'b1, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b0, 8'hFF, 1'b1, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b0, 8'hFF, 1'b1, 1'b1,
                                       mk_result(FC_STATUS, 0, 64'hFFFF, ST_NOT_QUOTE, 1'b1)));
        directed_rows.push_back(mk_row(1'b1, 8'h00, 1'b1, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b0, 8'hFF, 1'b0, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b0, 8'h54, 1'b0, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b0, 8'h43, 1'b0, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b0, 8'h47, 1'b0, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b0, 8'h80, 1'b0, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b0, 8'h18, 1'b0, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b0, 8'h00, 1'b0, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b0, 8'h02, 1'b0, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b0, 8'hFF, 1'b0, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b0, 8'h00, 1'b0, 1'b0, NO_RESULT));
        directed_rows.push_back(mk_row(1'b1, 8'h00, 1'b1, 1'b1,
                                       mk_result(FC_STATUS, 0, 0, ST_TOO_SHORT, 1'b1)));
        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].typed,
                      directed_rows[i].want, directed_rows[i].res);

        for (setting = 0; setting < 4; setting++)
        begin
            case (setting)
                0:
                begin
                    m = '0;
                    t = '0;
                end
                1:
                begin
                    m = '1;
                    t = '1;
                end
                2:
                begin
                    m = $urandom;
                    t = 16'($urandom);
                end
                default:
                begin
                    m = MAGIC_RESET;
                    t = TAG_RESET;
                end
            endcase
            wait_idle();
            write_reg(REG_MAGIC, m);
            write_reg(REG_TAG, {16'd0, t});
            sent = 0;
            while (sent < ITEMS_PER_SETTING)
            begin
                build_quote();
                steady_sender = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) == 0)
                    wait_idle();
                foreach (quote_bytes[i])
                    send_item(quote_bytes[i].op, quote_bytes[i].data, 1'b0, 1'b0, NO_RESULT);
                sent += quote_bytes.size();
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_fields.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/aqsp_pkg.sv
rtl/aqsp_in_if.sv
rtl/aqsp_out_if.sv
rtl/aqsp_step.sv
rtl/attest_quote_stream_parser_unit.sv
verif/tb_top.sv
